### src/ile_pkg.sv
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types, codes and widths of the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

	localparam int unsigned DEFAULT_CAPACITY = 16;

	localparam int unsigned CMD_W   = 2;
	localparam int unsigned POS_W   = 8;
	localparam int unsigned VAL_W   = 32;
	localparam int unsigned ST_W    = 2;
	localparam int unsigned NLEN_W  = 5;

	// command codes
	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd2;

	// status codes
	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_BAD_POS = 2'd1;
	localparam logic [ST_W-1:0] ST_EMPTY   = 2'd2;
	localparam logic [ST_W-1:0] ST_FULL    = 2'd3;

	// operation broadcast to every cell of the chain
	typedef struct packed {
		logic             ins;
		logic             rem;
		logic             rd;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] value;
	} cell_op_t;

endpackage

`default_nettype wire

### src/ile_if.sv
// ----------------------------------------------------------------------------
// ile_if
// Request and response channels of the indexed list engine.
// ----------------------------------------------------------------------------
`default_nettype none

interface ile_req_if;
	logic                        valid;
	logic                        ready;
	logic [ile_pkg::CMD_W-1:0]   cmd;
	logic [ile_pkg::POS_W-1:0]   position;
	logic signed [ile_pkg::VAL_W-1:0] item_value;

	modport source (output valid, cmd, position, item_value, input ready);
	modport sink   (input valid, cmd, position, item_value, output ready);
endinterface

interface ile_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [ile_pkg::ST_W-1:0]     status;
	logic signed [ile_pkg::VAL_W-1:0] read_value;
	logic [ile_pkg::NLEN_W-1:0]   new_length;

	modport source (output valid, status, read_value, new_length, input ready);
	modport sink   (input valid, status, read_value, new_length, output ready);
endinterface

`default_nettype wire

### src/indexed_list_engine_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_engine_unit
// Bounded ordered list of signed 32-bit values with insert, remove and read
// at a position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, one entry per cell, head in cell
// zero. An insert moves all cells past the position one slot toward the tail
// while the addressed cell loads the new value, a remove moves them one slot
// toward the head, and a read selects the addressed cell onto an OR bus. One
// request transfer is taken per clock as long as the response register is
// empty or being drained in the same cycle, so the sustained rate is one
// command per cycle; the response is registered and valid in the cycle after
// the request transfer. Each command gives exactly one response with status,
// read value (zero unless a successful read) and the new length truncated to
// five bits. Entries are not cleared at reset; only length and rsp valid are.
`default_nettype none

module indexed_list_engine_unit #(
	parameter int unsigned CAPACITY = ile_pkg::DEFAULT_CAPACITY
) (
	input  wire        clk,
	input  wire        arst_n,
	ile_req_if.sink    req,
	ile_rsp_if.source  rsp
);
	import ile_pkg::*;

	localparam int unsigned LEN_W = $clog2(CAPACITY + 1);

	// response holding register
	logic              rsp_valid_q;
	logic [ST_W-1:0]   status_q;
	logic [VAL_W-1:0]  read_value_q;
	logic [NLEN_W-1:0] new_length_q;

	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  next_length;
	logic [ST_W-1:0]   status;
	cell_op_t          op;
	logic              fire;

	logic [VAL_W-1:0]  cell_val [CAPACITY];
	logic [VAL_W-1:0]  cell_rd  [CAPACITY];
	logic [VAL_W-1:0]  rd_bus;

	// accept a new request whenever the response slot is free or draining
	assign req.ready = !rsp_valid_q || rsp.ready;
	assign fire      = req.valid && req.ready;

	ile_ctrl #(
		.CAPACITY (CAPACITY),
		.LEN_W    (LEN_W)
	) u_ctrl (
		.fire        (fire),
		.cmd         (req.cmd),
		.position    (req.position),
		.item_value  (req.item_value),
		.length      (length_q),
		.op          (op),
		.status      (status),
		.next_length (next_length)
	);

	// row of cells; the ends see a harmless neighbor value
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [VAL_W-1:0] left_v;
		logic [VAL_W-1:0] right_v;

		if (i == 0) begin : g_head
			assign left_v = op.value;
		end else begin : g_mid_l
			assign left_v = cell_val[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign right_v = cell_val[i];
		end else begin : g_mid_r
			assign right_v = cell_val[i+1];
		end

		ile_cell #(
			.INDEX (i)
		) u_cell (
			.clk       (clk),
			.op        (op),
			.left_val  (left_v),
			.right_val (right_v),
			.val       (cell_val[i]),
			.rd_data   (cell_rd[i])
		);
	end

	// at most one cell drives a nonzero value onto the read bus
	always_comb begin
		rd_bus = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				length_q    <= next_length;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q     <= status;
			read_value_q <= rd_bus;
			new_length_q <= NLEN_W'(next_length);
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.read_value = read_value_q;
	assign rsp.new_length = new_length_q;

endmodule

`default_nettype wire

### src/ile_cell.sv
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an entry, shifts toward head or tail with its
// neighbors, and drives its entry onto the read bus when addressed.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire                          clk,
	input  ile_pkg::cell_op_t            op,
	input  wire [ile_pkg::VAL_W-1:0]     left_val,
	input  wire [ile_pkg::VAL_W-1:0]     right_val,
	output logic [ile_pkg::VAL_W-1:0]    val,
	output logic [ile_pkg::VAL_W-1:0]    rd_data
);
	import ile_pkg::*;

	localparam logic [POS_W-1:0] MY_POS = POS_W'(INDEX);

	logic [VAL_W-1:0] val_q;
	logic             at_pos;
	logic             past_pos;

	assign at_pos   = (op.pos == MY_POS);
	assign past_pos = (MY_POS > op.pos);

	always_ff @(posedge clk) begin
		if (op.ins) begin
			if (at_pos) begin
				val_q <= op.value;
			end else if (past_pos) begin
				val_q <= left_val;
			end
		end else if (op.rem && (at_pos || past_pos)) begin
			val_q <= right_val;
		end
	end

	assign val     = val_q;
	assign rd_data = (op.rd && at_pos) ? val_q : '0;

endmodule

`default_nettype wire

### src/ile_ctrl.sv
// ----------------------------------------------------------------------------
// ile_ctrl
// Command decode and bounds checks; produces the cell operation, status and
// next length.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_ctrl #(
	parameter int unsigned CAPACITY = ile_pkg::DEFAULT_CAPACITY,
	parameter int unsigned LEN_W    = $clog2(CAPACITY + 1)
) (
	input  wire                          fire,
	input  wire [ile_pkg::CMD_W-1:0]     cmd,
	input  wire [ile_pkg::POS_W-1:0]     position,
	input  wire [ile_pkg::VAL_W-1:0]     item_value,
	input  wire [LEN_W-1:0]              length,
	output ile_pkg::cell_op_t            op,
	output logic [ile_pkg::ST_W-1:0]     status,
	output logic [LEN_W-1:0]             next_length
);
	import ile_pkg::*;

	localparam int unsigned CMP_W = (LEN_W > POS_W) ? LEN_W : POS_W;

	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] len_x;
	logic             empty;
	logic             full;
	logic             ok_ins;
	logic             ok_rem;
	logic             ok_rd;

	assign pos_x = CMP_W'(position);
	assign len_x = CMP_W'(length);
	assign empty = (length == '0);
	assign full  = (length == LEN_W'(CAPACITY));

	always_comb begin
		status = ST_BAD_POS;
		ok_ins = 1'b0;
		ok_rem = 1'b0;
		ok_rd  = 1'b0;
		case (cmd)
			CMD_INSERT: begin
				if (full) begin
					status = ST_FULL;
				end else if (empty || (pos_x <= len_x)) begin
					status = ST_OK;
					ok_ins = 1'b1;
				end
			end
			CMD_REMOVE: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_x < len_x) begin
					status = ST_OK;
					ok_rem = 1'b1;
				end
			end
			CMD_READ: begin
				if (empty) begin
					status = ST_EMPTY;
				end else if (pos_x < len_x) begin
					status = ST_OK;
					ok_rd  = 1'b1;
				end
			end
			default: begin
				status = ST_BAD_POS;
			end
		endcase
	end

	// an insert into an empty list always lands at the head
	always_comb begin
		op.ins   = fire && ok_ins;
		op.rem   = fire && ok_rem;
		op.rd    = ok_rd;
		op.pos   = empty ? '0 : position;
		op.value = item_value;
	end

	always_comb begin
		next_length = length;
		if (ok_ins) begin
			next_length = length + LEN_W'(1);
		end else if (ok_rem) begin
			next_length = length - LEN_W'(1);
		end
	end

endmodule

`default_nettype wire
